// File: hdl/pet_pkg.sv
// Shared types and constants for the point exclusion table.
// No dependencies; compiled first.
`default_nettype none

package pet_pkg;

  localparam int MAX_ENTRIES = 8;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  localparam int OP_W      = 2;
  localparam int COORD_W   = 16;
  localparam int RAD_W     = 12;
  localparam int LIM_W     = 2 * RAD_W;
  localparam int ADIFF_W   = COORD_W;        // |a - b| of two 16-bit coords fits 16 bits
  localparam int SQ_W      = 2 * ADIFF_W;
  localparam int SUM_W     = SQ_W + 1;
  localparam int ROOT_W    = SUM_W + 1;
  localparam int DIST_W    = 18;
  localparam int STAT_W    = 2;
  localparam int TOTAL_W   = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [RAD_W-1:0] REJECT_RESET = RAD_W'(100);
  localparam logic [RAD_W-1:0] DUP_RESET    = RAD_W'(250);

  // highest power of four that fits the squared distance
  localparam logic [ROOT_W-1:0] ROOT_BIT_INIT = ROOT_W'(1) << (2 * ((SUM_W - 1) / 2));

  localparam logic [CFG_IDX_W-1:0] REG_REJECT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DUP    = CFG_IDX_W'(1);

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_ADD    = 2'd1,
    OP_QUERY  = 2'd2,
    OP_UNUSED = 2'd3
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_STORED = 2'd0,
    ST_DUP    = 2'd1,
    ST_FULL   = 2'd2,
    ST_NONE   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_READ,
    S_SQUARE,
    S_COMPARE,
    S_ROOT,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic    load;
    logic    count_clr;
    logic    store;
    logic    idx_clr;
    logic    idx_inc;
    logic    rd;
    logic    sq;
    logic    set_near;
    logic    root_step;
    logic    set_status;
    status_e status;
    logic    out_load;
  } ctrl_t;

  typedef struct packed {
    op_e  op;
    logic empty;
    logic full;
    logic idx_last;
    logic hit;
    logic root_last;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: hdl/pet_intf.sv
// Handshake channels of the point exclusion table: input, result and config.
// Depends on pet_pkg.
`default_nettype none

interface pet_in_if;
  import pet_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           opcode;
  logic signed [COORD_W-1:0] x_coord;
  logic signed [COORD_W-1:0] y_coord;
  modport source (output valid, output opcode, output x_coord, output y_coord, input ready);
  modport sink   (input valid, input opcode, input x_coord, input y_coord, output ready);
endinterface

interface pet_out_if;
  import pet_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     near_found;
  logic signed [DIST_W-1:0] near_dist;
  logic [STAT_W-1:0]        add_status;
  logic [TOTAL_W-1:0]       entry_total;
  modport source (output valid, output near_found, output near_dist, output add_status,
                  output entry_total, input ready);
  modport sink   (input valid, input near_found, input near_dist, input add_status,
                  input entry_total, output ready);
endinterface

interface pet_cfg_if;
  import pet_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [RAD_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/pet_datapath.sv
// Datapath: radius registers, point store, squared-distance unit,
// bit-serial square root and the result register. Depends on pet_pkg.
`default_nettype none

module pet_datapath (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire  [pet_pkg::OP_W-1:0]          opcode_i,
  input  wire  signed [pet_pkg::COORD_W-1:0] x_coord_i,
  input  wire  signed [pet_pkg::COORD_W-1:0] y_coord_i,
  input  wire                               cfg_we_i,
  input  wire  [pet_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire  [pet_pkg::RAD_W-1:0]         cfg_data_i,
  input  pet_pkg::ctrl_t                    ctrl_i,
  output pet_pkg::dp_stat_t                 stat_o,
  output logic                              near_found_o,
  output logic signed [pet_pkg::DIST_W-1:0] near_dist_o,
  output logic [pet_pkg::STAT_W-1:0]        add_status_o,
  output logic [pet_pkg::TOTAL_W-1:0]       entry_total_o
);
  import pet_pkg::*;

  logic [RAD_W-1:0]   reject_q, dup_q;
  op_e                op_q;
  logic [COORD_W-1:0] x_q, y_q;
  logic [LIM_W-1:0]   lim_q;
  logic [CNT_W-1:0]   count_q;
  logic [IDX_W-1:0]   idx_q;

  logic [COORD_W-1:0] mem_x [MAX_ENTRIES];
  logic [COORD_W-1:0] mem_y [MAX_ENTRIES];
  logic [COORD_W-1:0] rd_x_q, rd_y_q;

  logic [SQ_W-1:0]    sqx_q, sqy_q;
  logic               near_q;
  status_e            status_q;
  logic [SUM_W-1:0]   rem_q;
  logic [ROOT_W-1:0]  res_q, bit_q;

  logic [RAD_W-1:0]   rad_w;
  logic [LIM_W-1:0]   rad_ext;
  logic signed [COORD_W:0] dx, dy;
  logic [ADIFF_W-1:0] adx_full, ady_full;
  logic [SQ_W-1:0]    adx_ext, ady_ext;
  logic [SUM_W-1:0]   sum_w;
  logic [ROOT_W-1:0]  trial;
  logic               take;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reject_q <= REJECT_RESET;
      dup_q    <= DUP_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_REJECT: reject_q <= cfg_data_i;
        REG_DUP:    dup_q    <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  assign rad_w   = (op_e'(opcode_i) == OP_ADD) ? dup_q : reject_q;
  assign rad_ext = LIM_W'(rad_w);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      op_q  <= op_e'(opcode_i);
      x_q   <= x_coord_i;
      y_q   <= y_coord_i;
      lim_q <= rad_ext * rad_ext;
    end
  end

  // entry count and scan index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (ctrl_i.count_clr) begin
      count_q <= '0;
    end else if (ctrl_i.store) begin
      count_q <= count_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.idx_clr) begin
      idx_q <= '0;
    end else if (ctrl_i.idx_inc) begin
      idx_q <= idx_q + IDX_W'(1);
    end
  end

  // point store, registered read
  always_ff @(posedge clk_i) begin
    if (ctrl_i.store) begin
      mem_x[count_q[IDX_W-1:0]] <= x_q;
      mem_y[count_q[IDX_W-1:0]] <= y_q;
    end
    if (ctrl_i.rd) begin
      rd_x_q <= mem_x[idx_q];
      rd_y_q <= mem_y[idx_q];
    end
  end

  // squared distance
  assign dx       = $signed({x_q[COORD_W-1], x_q}) - $signed({rd_x_q[COORD_W-1], rd_x_q});
  assign dy       = $signed({y_q[COORD_W-1], y_q}) - $signed({rd_y_q[COORD_W-1], rd_y_q});
  assign adx_full = dx[COORD_W] ? ADIFF_W'(-dx) : ADIFF_W'(dx);
  assign ady_full = dy[COORD_W] ? ADIFF_W'(-dy) : ADIFF_W'(dy);
  assign adx_ext  = SQ_W'(adx_full);
  assign ady_ext  = SQ_W'(ady_full);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.sq) begin
      sqx_q <= adx_ext * adx_ext;
      sqy_q <= ady_ext * ady_ext;
    end
  end

  assign sum_w = SUM_W'(sqx_q) + SUM_W'(sqy_q);

  // result fields and square root, one result bit per step
  assign trial = res_q + bit_q;
  assign take  = ROOT_W'(rem_q) >= trial;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      near_q   <= 1'b0;
      status_q <= ST_NONE;
    end else begin
      if (ctrl_i.set_near) begin
        near_q <= 1'b1;
      end
      if (ctrl_i.set_status) begin
        status_q <= ctrl_i.status;
      end
    end
    if (ctrl_i.set_near) begin
      rem_q <= sum_w;
      res_q <= '0;
      bit_q <= ROOT_BIT_INIT;
    end else if (ctrl_i.root_step) begin
      if (take) begin
        rem_q <= rem_q - trial[SUM_W-1:0];
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  // output word register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) begin
      near_found_o  <= near_q;
      near_dist_o   <= near_q ? $signed(DIST_W'(res_q)) : '1;
      add_status_o  <= status_q;
      entry_total_o <= TOTAL_W'(count_q);
    end
  end

  assign stat_o.op        = op_q;
  assign stat_o.empty     = (count_q == '0);
  assign stat_o.full      = (count_q >= CNT_W'(MAX_ENTRIES));
  assign stat_o.idx_last  = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);
  assign stat_o.hit       = (sum_w <= SUM_W'(lim_q));
  assign stat_o.root_last = bit_q[0];

endmodule

`default_nettype wire

// File: hdl/pet_ctrl.sv
// Controller: sequences clear, add and query words over the datapath and
// owns the output valid flag. Depends on pet_pkg.
`default_nettype none

module pet_ctrl (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  input  pet_pkg::dp_stat_t  stat_i,
  output pet_pkg::ctrl_t     ctrl_o
);
  import pet_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    ctrl_o     = '0;
    ctrl_o.status = ST_NONE;
    in_ready_o = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.load = 1'b1;
          state_d     = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_d = S_FINISH;
        unique case (stat_i.op) inside
          OP_CLEAR: ctrl_o.count_clr = 1'b1;
          OP_ADD, OP_QUERY: begin
            if (!stat_i.empty) begin
              ctrl_o.idx_clr = 1'b1;
              state_d        = S_READ;
            end else if (stat_i.op == OP_ADD) begin
              ctrl_o.store      = 1'b1;
              ctrl_o.set_status = 1'b1;
              ctrl_o.status     = ST_STORED;
            end
          end
          default: ;
        endcase
      end
      S_READ: begin
        ctrl_o.rd = 1'b1;
        state_d   = S_SQUARE;
      end
      S_SQUARE: begin
        ctrl_o.sq = 1'b1;
        state_d   = S_COMPARE;
      end
      S_COMPARE: begin
        if (stat_i.hit) begin
          if (stat_i.op == OP_ADD) begin
            ctrl_o.set_status = 1'b1;
            ctrl_o.status     = ST_DUP;
            state_d           = S_FINISH;
          end else begin
            ctrl_o.set_near = 1'b1;
            state_d         = S_ROOT;
          end
        end else if (stat_i.idx_last) begin
          state_d = S_FINISH;
          if (stat_i.op == OP_ADD) begin
            ctrl_o.set_status = 1'b1;
            if (stat_i.full) begin
              ctrl_o.status = ST_FULL;
            end else begin
              ctrl_o.status = ST_STORED;
              ctrl_o.store  = 1'b1;
            end
          end
        end else begin
          ctrl_o.idx_inc = 1'b1;
          state_d        = S_READ;
        end
      end
      S_ROOT: begin
        ctrl_o.root_step = 1'b1;
        if (stat_i.root_last) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (slot_free) begin
          ctrl_o.out_load = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// File: hdl/point_exclusion_table.sv
// Top level of the point exclusion table: joins controller and datapath
// to the channel interfaces. Depends on pet_pkg, pet_intf, pet_ctrl, pet_datapath.
//
//   channel  dir  payload                                          notes
//   in_i     in   opcode, x_coord, y_coord                         one word per item
//   out_o    out  near_found, near_dist, add_status, entry_total   one word per item
//   cfg_i    in   index, data (12-bit radius)                      always ready
//
// One word in flight. Clear and unused opcodes go from accept through dispatch to the
// output register; add and query also scan the stored entries (read, square,
// compare), and a query hit adds the one-bit-per-step square root. Reset empties
// the table and loads the radius defaults. A finished word sits in the output
// register; the next input is taken while it waits, and only the final hand-off
// stalls on out ready.
`default_nettype none

module point_exclusion_table (
  input  wire     clk_i,
  input  wire     rst_ni,
  pet_in_if.sink  in_i,
  pet_out_if.source out_o,
  pet_cfg_if.sink cfg_i
);
  import pet_pkg::*;

  ctrl_t    ctrl;
  dp_stat_t stat;

  assign cfg_i.ready = 1'b1;

  pet_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  pet_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .opcode_i      (in_i.opcode),
    .x_coord_i     (in_i.x_coord),
    .y_coord_i     (in_i.y_coord),
    .cfg_we_i      (cfg_i.valid),
    .cfg_index_i   (cfg_i.index),
    .cfg_data_i    (cfg_i.data),
    .ctrl_i        (ctrl),
    .stat_o        (stat),
    .near_found_o  (out_o.near_found),
    .near_dist_o   (out_o.near_dist),
    .add_status_o  (out_o.add_status),
    .entry_total_o (out_o.entry_total)
  );

endmodule

`default_nettype wire
